[hdl/fds_pkg.sv]
// Shared types and constants for the firmware download session block.
// Used by fds_core and firmware_download_session; no dependencies.
package fds_pkg;

  localparam int unsigned PACKET_BYTES = 1024;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SEQ_W    = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Input beat: tdata holds image_size, seq, write_ok; tuser holds command
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [SEQ_W-1:0]  SEQ_IDLE          = 8'hFF;
  localparam logic [WORD_W-1:0] IMAGE_LIMIT_RESET = 32'd1048576;
  localparam logic [WORD_W-1:0] BASE_ADDR_RESET   = 32'd0;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_PACKET = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TOO_LARGE   = 3'd1,
    ST_NO_SESSION  = 3'd2,
    ST_SEQ_ERROR   = 3'd3,
    ST_WRITE_FAIL  = 3'd4,
    ST_FINISH_REJ  = 3'd5
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] total_bytes;
    logic [SEQ_W-1:0]  prev_seq;
    logic [WORD_W-1:0] received_bytes;
    logic [WORD_W-1:0] next_address;
    logic              valid_mark;
  } session_t;

  typedef struct packed {
    logic              image_valid;
    logic [WORD_W-1:0] write_address;
    logic              write_taken;
    logic              erase_request;
    status_e           status;
  } result_t;

endpackage

[hdl/firmware_download_session.sv]
// Top level of the firmware download session receiver.
// Depends on fds_pkg and fds_core.
//
// One command beat in, one result beat out. Each accepted command updates the
// session registers at the same clock edge and loads its result into a single
// output register, so the block takes one command per cycle for as long as the
// result side keeps up; the result beat is valid in the cycle after acceptance.
// The output register is the only buffer: s_axis_tready is high whenever it is
// empty or is being drained in the same cycle. The session state (announced
// size, last sequence, received byte count, next flash address, image-valid
// mark) is plain flip-flops; a start, a failed write or a cancel reloads the
// next address from base_address, so a new base takes effect there. Write the
// configuration registers only while no command is in flight. Register index 0
// is image_limit, index 1 is base_address, other indexes are ignored.
module firmware_download_session (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] image_size, [39:32] seq, [40] write_ok, [47:41] zero
  input  logic [fds_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [fds_pkg::CMD_W-1:0]         s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] status, [3] erase_request, [4] write_taken, [36:5] write_address,
  // [37] image_valid, [39:38] zero
  output logic [fds_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [fds_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fds_pkg::WORD_W-1:0]        cfg_wdata_i
);

  logic [fds_pkg::WORD_W-1:0] image_limit_q;
  logic [fds_pkg::WORD_W-1:0] base_address_q;

  fds_pkg::session_t session_q, session_d;
  fds_pkg::result_t  result_d, result_q;
  logic              out_valid_q;
  logic              accept;

  // Take a new beat when the result register is empty or drains now
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_limit_q  <= fds_pkg::IMAGE_LIMIT_RESET;
      base_address_q <= fds_pkg::BASE_ADDR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fds_pkg::REG_IMAGE_LIMIT:  image_limit_q  <= cfg_wdata_i;
        fds_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_wdata_i;
        default: begin
          image_limit_q <= image_limit_q;
        end
      endcase
    end
  end

  fds_core u_core (
    .state_i        (session_q),
    .command_i      (fds_pkg::cmd_e'(s_axis_tuser)),
    .image_size_i   (s_axis_tdata[31:0]),
    .seq_i          (s_axis_tdata[39:32]),
    .write_ok_i     (s_axis_tdata[40]),
    .image_limit_i  (image_limit_q),
    .base_address_i (base_address_q),
    .state_o        (session_d),
    .result_o       (result_d)
  );

  // Session state: advance on every accepted command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q.total_bytes    <= '0;
      session_q.prev_seq       <= fds_pkg::SEQ_IDLE;
      session_q.received_bytes <= '0;
      session_q.next_address   <= fds_pkg::BASE_ADDR_RESET;
      session_q.valid_mark     <= 1'b0;
    end else if (accept) begin
      session_q <= session_d;
    end
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, result_q.image_valid, result_q.write_address,
                          result_q.write_taken, result_q.erase_request,
                          result_q.status};

endmodule

[hdl/fds_core.sv]
// Command decode and next-session logic for one command beat.
// Depends on fds_pkg.
module fds_core (
  input  fds_pkg::session_t             state_i,
  input  fds_pkg::cmd_e                 command_i,
  input  logic [fds_pkg::WORD_W-1:0]    image_size_i,
  input  logic [fds_pkg::SEQ_W-1:0]     seq_i,
  input  logic                          write_ok_i,
  input  logic [fds_pkg::WORD_W-1:0]    image_limit_i,
  input  logic [fds_pkg::WORD_W-1:0]    base_address_i,
  output fds_pkg::session_t             state_o,
  output fds_pkg::result_t              result_o
);

  fds_pkg::session_t         closed;
  logic                      open;
  logic [fds_pkg::WORD_W:0]  rx_sum;
  logic [fds_pkg::WORD_W-1:0] rx_next;
  logic [fds_pkg::WORD_W-1:0] rx_excess;
  logic                      finish_ok;

  always_comb begin
    closed                = state_i;
    closed.total_bytes    = '0;
    closed.prev_seq       = fds_pkg::SEQ_IDLE;
    closed.received_bytes = '0;
    closed.next_address   = base_address_i;
  end

  assign open      = (state_i.total_bytes != '0);
  assign rx_sum    = {1'b0, state_i.received_bytes}
                   + (fds_pkg::WORD_W+1)'(fds_pkg::PACKET_BYTES);
  // saturate the byte count
  assign rx_next   = rx_sum[fds_pkg::WORD_W] ? '1 : rx_sum[fds_pkg::WORD_W-1:0];
  assign rx_excess = state_i.received_bytes - state_i.total_bytes;
  assign finish_ok = open && (seq_i == state_i.prev_seq)
                   && (state_i.received_bytes >= state_i.total_bytes)
                   && (rx_excess < fds_pkg::WORD_W'(fds_pkg::PACKET_BYTES));

  always_comb begin
    state_o                = state_i;
    result_o.status        = fds_pkg::ST_OK;
    result_o.erase_request = 1'b0;
    result_o.write_taken   = 1'b0;
    result_o.write_address = '0;
    unique case (command_i)
      fds_pkg::CMD_START: begin
        if (image_size_i > image_limit_i) begin
          result_o.status = fds_pkg::ST_TOO_LARGE;
        end else begin
          result_o.erase_request = 1'b1;
          state_o                = closed;
          state_o.total_bytes    = image_size_i;
          state_o.valid_mark     = 1'b0;
        end
      end
      fds_pkg::CMD_PACKET: begin
        if (!open) begin
          result_o.status = fds_pkg::ST_NO_SESSION;
        end else if (seq_i == state_i.prev_seq + 8'd1) begin
          result_o.write_taken   = 1'b1;
          result_o.write_address = state_i.next_address;
          if (write_ok_i) begin
            state_o.prev_seq       = seq_i;
            state_o.received_bytes = rx_next;
            state_o.next_address   = state_i.next_address
                                   + fds_pkg::WORD_W'(fds_pkg::PACKET_BYTES);
          end else begin
            state_o         = closed;
            result_o.status = fds_pkg::ST_WRITE_FAIL;
          end
        end else if (seq_i != state_i.prev_seq) begin
          result_o.status = fds_pkg::ST_SEQ_ERROR;
        end
      end
      fds_pkg::CMD_FINISH: begin
        if (finish_ok) begin
          state_o.valid_mark = 1'b1;
        end else begin
          result_o.status = fds_pkg::ST_FINISH_REJ;
        end
      end
      fds_pkg::CMD_CANCEL: begin
        state_o = closed;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.image_valid = state_o.valid_mark;
  end

endmodule

[verif/tb.sv]
// Self-checking bench for firmware_download_session: drives command beats, predicts each
// session reply in SystemVerilog and compares every result beat field by field.
// Depends on fds_pkg and the firmware_download_session RTL only.
module tb;
  import fds_pkg::*;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Cycles without any beat on either side before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Cycles to let pass once the last reply is in.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned QUIET_ITEMS   = 150;
  localparam int unsigned REPORT_CAP    = 60;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = CMD_CANCEL;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_IMAGE_LIMIT;
  logic [WORD_W-1:0]      cfg_wdata_i = '0;

  firmware_download_session DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Session predictor: own copy of the registers and the session state.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] limit_reg;
  logic [WORD_W-1:0] base_reg;
  logic [WORD_W-1:0] announced_bytes;   // zero means no open session
  logic [SEQ_W-1:0]  prev_seq;
  logic [WORD_W-1:0] landed_bytes;
  logic [WORD_W-1:0] flash_addr;
  logic              image_mark;

  result_t expected_replies[$];
  int unsigned commands_sent = 0;
  int unsigned mismatch_count = 0;
  bit          idle_on = 1'b1;

  // Drop the session; the flash pointer reloads from the current base register.
  function automatic void drop_session();
    announced_bytes = '0;
    prev_seq        = SEQ_IDLE;
    landed_bytes    = '0;
    flash_addr      = base_reg;
  endfunction

  function automatic result_t session_reply(cmd_e cmd, logic [WORD_W-1:0] size,
                                            logic [SEQ_W-1:0] seq, logic wok);
    result_t            r;
    logic [SEQ_W-1:0]   next_seq;
    logic [WORD_W:0]    sum;
    logic [WORD_W-1:0]  overshoot;
    r        = '0;
    r.status = ST_OK;
    next_seq = prev_seq + 8'd1;
    case (cmd)
      CMD_START: begin
        if (size > limit_reg) begin
          r.status = ST_TOO_LARGE;
        end else begin
          r.erase_request = 1'b1;
          drop_session();
          announced_bytes = size;
          image_mark      = 1'b0;
        end
      end
      CMD_PACKET: begin
        if (announced_bytes == '0) begin
          r.status = ST_NO_SESSION;
        end else if (seq == next_seq) begin
          r.write_taken   = 1'b1;
          r.write_address = flash_addr;
          if (wok) begin
            // Byte count saturates, the address wraps.
            sum          = {1'b0, landed_bytes} + PACKET_BYTES;
            prev_seq     = seq;
            landed_bytes = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
            flash_addr   = flash_addr + PACKET_BYTES;
          end else begin
            drop_session();
            r.status = ST_WRITE_FAIL;
          end
        end else if (seq != prev_seq) begin
          r.status = ST_SEQ_ERROR;
        end
      end
      CMD_FINISH: begin
        overshoot = landed_bytes - announced_bytes;
        if (announced_bytes != '0 && seq == prev_seq &&
            landed_bytes >= announced_bytes && overshoot < PACKET_BYTES) begin
          image_mark = 1'b1;
        end else begin
          r.status = ST_FINISH_REJ;
        end
      end
      default: begin
        drop_session();
      end
    endcase
    r.image_valid = image_mark;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Every task returns right after a rising edge; the valid stays
  // high after an accepted beat so that back-to-back commands see no bubble.
  // ---------------------------------------------------------------------------
  task automatic send_command(cmd_e cmd, logic [WORD_W-1:0] size,
                              logic [SEQ_W-1:0] seq, logic wok);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, wok, seq, size};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_replies.push_back(session_reply(cmd, size, seq, wok));
    commands_sent++;
  endtask

  // Hold the command side idle and wait for every reply to drain.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] value);
    drain_replies();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      REG_IMAGE_LIMIT:  limit_reg = value;
      REG_BASE_ADDRESS: base_reg  = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts while idling is on.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Compare every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_replies.pop_front();
        check_field("status",        want.status,        got.status);
        check_field("erase_request", want.erase_request, got.erase_request);
        check_field("write_taken",   want.write_taken,   got.write_taken);
        check_field("write_address", want.write_address, got.write_address);
        check_field("image_valid",   want.image_valid,   got.image_valid);
        check_field("pad", '0, m_axis_tdata[OUT_DATA_W-1:$bits(result_t)]);
      end
    end
  end

  // Watchdog: count cycles with no beat accepted on either side.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands with no session open: packet and finish are refused, cancel is harmless.
  task automatic test_no_session();
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    send_command(CMD_FINISH, 32'hFFFF_FFFF, SEQ_IDLE, 1'b0);
    send_command(CMD_CANCEL, 32'hFFFF_FFFF, 8'hFF, 1'b1);
  endtask

  // Size checks against the default limit, and a zero-size start that opens nothing.
  task automatic test_start_limits();
    send_command(CMD_START, 32'd0, 8'h00, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    send_command(CMD_START, IMAGE_LIMIT_RESET, 8'hA5, 1'b1);
    send_command(CMD_START, IMAGE_LIMIT_RESET + 32'd1, 8'd0, 1'b0);
    send_command(CMD_START, 32'hFFFF_FFFF, 8'hFF, 1'b1);
  endtask

  // In-order packets, a repeat, a gap, finish reject and accept, cancel keeping the
  // mark, restart clearing it, and a failed write closing the session.
  task automatic test_packet_sequence();
    send_command(CMD_START, 32'd3000, 8'd0, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    send_command(CMD_PACKET, 32'd0, 8'd1, 1'b1);
    send_command(CMD_PACKET, 32'd0, 8'd1, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd7, 1'b1);
    send_command(CMD_PACKET, 32'd0, 8'd2, 1'b1);
    send_command(CMD_FINISH, 32'd0, 8'd1, 1'b0);
    send_command(CMD_FINISH, 32'd0, 8'd2, 1'b0);
    send_command(CMD_CANCEL, 32'd0, 8'd0, 1'b0);
    send_command(CMD_START, 32'd2048, 8'd0, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd1, 1'b1);
  endtask

  // Limit and base at their extremes; a new base only lands when the session closes, as at cancel or start;
  // the flash address wraps; writes to unmapped indexes change nothing.
  task automatic test_register_writes();
    write_register(REG_IMAGE_LIMIT, 32'd0);
    send_command(CMD_START, 32'd0, 8'd0, 1'b0);
    send_command(CMD_START, 32'd1, 8'd0, 1'b0);
    write_register(REG_IMAGE_LIMIT, 32'hFFFF_FFFF);
    send_command(CMD_START, 32'hFFFF_FFFF, 8'd0, 1'b0);
    write_register(REG_BASE_ADDRESS, 32'hFFFF_FC00);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    send_command(CMD_CANCEL, 32'd0, 8'd0, 1'b0);
    send_command(CMD_START, 32'd4096, 8'd0, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    send_command(CMD_PACKET, 32'd0, 8'd1, 1'b1);
    write_register(REG_SPARE_A, 32'd0);
    write_register(REG_SPARE_B, 32'h1234_5678);
    send_command(CMD_START, 32'd8, 8'd0, 1'b0);
    send_command(CMD_PACKET, 32'd0, 8'd0, 1'b1);
    write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
  endtask

  // One download with random content: start, npk packets with the odd repeat,
  // stray or failed write, then mostly a finish on the last sequence.
  task automatic run_session(int unsigned npk);
    logic [WORD_W-1:0] size;
    logic [SEQ_W-1:0]  seq;
    case ($urandom_range(0, 9))
      0:       size = $urandom;
      1:       size = npk * PACKET_BYTES;
      2:       size = npk * PACKET_BYTES - (PACKET_BYTES - 1);
      3:       size = npk * PACKET_BYTES - PACKET_BYTES;
      default: size = $urandom_range(1, npk * PACKET_BYTES);
    endcase
    send_command(CMD_START, size, SEQ_W'($urandom), 1'($urandom));
    for (int unsigned i = 0; i < npk; i++) begin
      seq = i[SEQ_W-1:0];
      case ($urandom_range(0, 24))
        0: send_command(CMD_PACKET, $urandom, seq - 8'd1, 1'($urandom));
        1: send_command(CMD_PACKET, $urandom, SEQ_W'($urandom), 1'($urandom));
        default: ;
      endcase
      send_command(CMD_PACKET, $urandom, seq, $urandom_range(0, 39) != 0);
    end
    seq = SEQ_W'(npk - 1);
    case ($urandom_range(0, 9))
      0:       send_command(CMD_CANCEL, $urandom, SEQ_W'($urandom), 1'($urandom));
      1:       send_command(CMD_FINISH, $urandom, SEQ_W'($urandom), 1'($urandom));
      2:       ;
      default: send_command(CMD_FINISH, $urandom, seq, 1'($urandom));
    endcase
  endtask

  // Mostly well-formed downloads, some loose commands of any kind.
  task automatic run_traffic(int unsigned item_goal);
    while (commands_sent < item_goal) begin
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4))
          send_command(cmd_e'($urandom_range(0, 3)), $urandom, SEQ_W'($urandom),
                       1'($urandom));
      else
        run_session($urandom_range(1, 12));
    end
  endtask

  // Four register settings, one long download that wraps the sequence number,
  // and one stretch without idling in the middle.
  task automatic test_random_traffic();
    int unsigned phase_goal;
    for (int unsigned p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_register(REG_IMAGE_LIMIT, IMAGE_LIMIT_RESET);
          write_register(REG_BASE_ADDRESS, $urandom);
        end
        1: begin
          write_register(REG_IMAGE_LIMIT, 32'hFFFF_FFFF);
          write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        end
        2: begin
          write_register(REG_IMAGE_LIMIT, $urandom_range(4096, 1 << 20));
          write_register(REG_BASE_ADDRESS, 32'd0);
        end
        default: begin
          write_register(REG_IMAGE_LIMIT, 32'd5000);
          write_register(REG_BASE_ADDRESS, $urandom);
        end
      endcase
      idle_on    = (p != 2);
      phase_goal = commands_sent + RANDOM_ITEMS / 4;
      if (p == 0) run_session(260);
      run_traffic(phase_goal);
    end
    idle_on = 1'b1;
  endtask

  // Full-rate traffic at the end: no gaps on the command side, no stalls on results.
  task automatic test_full_rate();
    drain_replies();
    idle_on = 1'b0;
    run_traffic(commands_sent + QUIET_ITEMS);
  endtask

  initial begin
    limit_reg  = IMAGE_LIMIT_RESET;
    base_reg   = BASE_ADDR_RESET;
    image_mark = 1'b0;
    drop_session();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_session();
    test_start_limits();
    test_packet_sequence();
    test_register_writes();
    test_random_traffic();
    test_full_rate();

    drain_replies();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
